/* rtl/bsd_pkg.sv */
// bsd_pkg: types, constants and the character classifier of the base64 stream decoder
// used by bsd_front, bsd_queue, bsd_back and base64_stream_decoder_unit
package bsd_pkg;

  localparam int TOTAL_W = 24;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam logic [6:0] CODE_PAD = 7'd64;
  localparam logic [6:0] CODE_BAD = 7'd65;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FORMAT  = 2'd1,
    ST_NOSPACE = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       char_present;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               is_status;
    status_e            status;
    logic [TOTAL_W-1:0] total_bytes;
    logic               run_last;
  } out_item_t;

  // one accepted item's worth of results
  typedef struct packed {
    logic [2:0][7:0]    data;
    logic [1:0]         nbytes;
    logic               has_status;
    status_e            status;
    logic [TOTAL_W-1:0] base;
  } job_t;

  function automatic logic [6:0] sextet(input logic [7:0] ch);
    logic [6:0] code;
    code = CODE_BAD;
    if (ch inside {[CH_UA:CH_UZ]}) begin
      code = 7'(ch - CH_UA);
    end else if (ch inside {[CH_LA:CH_LZ]}) begin
      code = 7'(ch - CH_LA + 8'd26);
    end else if (ch inside {[CH_D0:CH_D9]}) begin
      code = 7'(ch - CH_D0 + 8'd52);
    end else if (ch == CH_PLUS) begin
      code = 7'd62;
    end else if (ch == CH_SLASH) begin
      code = 7'd63;
    end else if (ch == CH_EQ) begin
      code = CODE_PAD;
    end
    return code;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

endpackage

/* rtl/bsd_front.sv */
// bsd_front: accepts characters, keeps the open group, counts bytes and raises errors
// depends on bsd_pkg; hands one job per result-producing request to the queue
module bsd_front #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bsd_pkg::in_item_t in_data_i,
  input  logic              cfg_we_i,
  input  logic [23:0]       cfg_wdata_i,
  input  logic              q_full_i,
  output logic              push_o,
  output bsd_pkg::job_t     job_o
);

  localparam int LW = ((COUNT_WIDTH > bsd_pkg::TOTAL_W) ? COUNT_WIDTH : bsd_pkg::TOTAL_W) + 1;
  localparam logic [LW-1:0] CMAX = LW'({COUNT_WIDTH{1'b1}});

  logic [23:0]            cap_q;
  logic [2:0][6:0]        chars_q, chars_d;
  logic [1:0]             fill_q, fill_d;
  logic [COUNT_WIDTH-1:0] bytes_q, bytes_d;
  bsd_pkg::status_e       err_q, err_d;

  logic          accept;
  logic [6:0]    code;
  logic [23:0]   v;
  logic [1:0]    emit;
  logic          grp_bad;
  logic [LW-1:0] limit, sum, bytes_ext;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign code       = bsd_pkg::sextet(in_data_i.in_char);
  assign v          = {chars_q[0][5:0], chars_q[1][5:0], chars_q[2][5:0], code[5:0]};
  assign bytes_ext  = LW'(bytes_q);
  assign limit      = (LW'(cap_q) < CMAX) ? LW'(cap_q) : CMAX;
  assign sum        = bytes_ext + LW'(emit);

  // group decode with the incoming char as the fourth one
  always_comb begin
    grp_bad = 1'b0;
    emit    = 2'd0;
    if (chars_q[0][6] || chars_q[1][6]) begin
      grp_bad = 1'b1;
    end else if (chars_q[2] == bsd_pkg::CODE_PAD && code == bsd_pkg::CODE_PAD) begin
      emit = 2'd1;
    end else if (!chars_q[2][6] && code == bsd_pkg::CODE_PAD) begin
      emit = 2'd2;
    end else if (!chars_q[2][6] && !code[6]) begin
      emit = 2'd3;
    end else begin
      grp_bad = 1'b1;
    end
  end

  always_comb begin
    chars_d = chars_q;
    fill_d  = fill_q;
    bytes_d = bytes_q;
    err_d   = err_q;
    job_o   = '0;
    job_o.data   = {v[7:0], v[15:8], v[23:16]};
    job_o.base   = bsd_pkg::TOTAL_W'(bytes_ext);
    job_o.status = bsd_pkg::ST_OK;
    push_o  = 1'b0;
    if (accept) begin
      if (in_data_i.char_present && err_q == bsd_pkg::ST_OK &&
          !bsd_pkg::is_space(in_data_i.in_char)) begin
        if (code == bsd_pkg::CODE_BAD) begin
          err_d = bsd_pkg::ST_FORMAT;
        end else if (fill_q != 2'd3) begin
          chars_d[fill_q] = code;
          fill_d          = fill_q + 2'd1;
        end else begin
          fill_d = 2'd0;
          if (grp_bad) begin
            err_d = bsd_pkg::ST_FORMAT;
          end else if (sum > limit) begin
            err_d = bsd_pkg::ST_NOSPACE;
          end else begin
            bytes_d      = COUNT_WIDTH'(sum);
            job_o.nbytes = emit;
          end
        end
      end
      if (in_data_i.end_of_input) begin
        job_o.has_status = 1'b1;
        job_o.status     = (err_d == bsd_pkg::ST_OK && fill_d != 2'd0) ?
                           bsd_pkg::ST_FORMAT : err_d;
        fill_d  = 2'd0;
        bytes_d = '0;
        err_d   = bsd_pkg::ST_OK;
      end
      push_o = (job_o.nbytes != 2'd0) || job_o.has_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= 24'hFFFFFF;
      fill_q  <= 2'd0;
      bytes_q <= '0;
      err_q   <= bsd_pkg::ST_OK;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      fill_q  <= fill_d;
      bytes_q <= bytes_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

endmodule

/* rtl/bsd_queue.sv */
// bsd_queue: short job queue between the front and the back of the decoder
// depends on bsd_pkg for the job type and depth
module bsd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bsd_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bsd_pkg::job_t job_o
);

  bsd_pkg::job_t                  mem_q [bsd_pkg::Q_DEPTH];
  logic [bsd_pkg::Q_PTR_W-1:0]    wr_q, rd_q;
  logic [bsd_pkg::Q_PTR_W:0]      cnt_q;

  assign full_o  = (cnt_q == (bsd_pkg::Q_PTR_W+1)'(bsd_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

/* rtl/bsd_back.sv */
// bsd_back: turns queued jobs into result items, one a cycle while the output is accepted, through an output register
// depends on bsd_pkg for the job and result types
module bsd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  bsd_pkg::job_t      job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsd_pkg::out_item_t out_data_o
);

  logic [1:0]         idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  bsd_pkg::out_item_t out_q, res;
  logic [2:0]         n_res;
  logic               last, load;

  assign n_res = {1'b0, job_i.nbytes} + {2'b00, job_i.has_status};
  assign last  = ({1'b0, idx_q} == (n_res - 3'd1));
  assign load  = valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && last;

  always_comb begin
    res = '0;
    res.run_last = last;
    if (idx_q < job_i.nbytes) begin
      res.out_byte    = job_i.data[idx_q];
      res.is_status   = 1'b0;
      res.status      = bsd_pkg::ST_OK;
      res.total_bytes = job_i.base + bsd_pkg::TOTAL_W'(idx_q) + 1'b1;
    end else begin
      res.out_byte    = 8'd0;
      res.is_status   = 1'b1;
      res.status      = job_i.status;
      res.total_bytes = job_i.base + bsd_pkg::TOTAL_W'(job_i.nbytes);
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/base64_stream_decoder_unit.sv */
// base64_stream_decoder_unit: top level of the base64 stream decoder
// depends on bsd_pkg, bsd_front, bsd_queue and bsd_back
// path: the first result of a request is registered in the job queue, then in the output register
// throughput: one request a cycle while the four-entry job queue has room; the
//   back end drains one result a cycle while out_ready_i accepts it
// reset: asynchronous, clears group fill, byte count, error, queue and output valid;
//   capacity returns to 0xFFFFFF, no clearing pass
module base64_stream_decoder_unit #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bsd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsd_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [23:0]        cfg_wdata_i
);

  logic          q_full, push, pop, q_valid;
  bsd_pkg::job_t job_in, job_out;

  bsd_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  bsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .job_o  (job_out)
  );

  bsd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
